// ----- rtl/windowed_pca_shift_statistic_assert.svh -----
// assertion macros shared by the shift statistic rtl
`ifndef WINDOWED_PCA_SHIFT_STATISTIC_ASSERT_SVH
`define WINDOWED_PCA_SHIFT_STATISTIC_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WPSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpss check failed");

// antecedent implies consequent in the next cycle
`define WPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpss check failed");

`endif

// ----- rtl/wpss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_pkg
// shared types and constants of the windowed pca shift statistic
// ----------------------------------------------------------------------------
package wpss_pkg;

  // largest window the dot accumulator is sized for
  localparam int unsigned WINDOW_MAX_DEF = 4096;

  // depth of the queue between front and back
  localparam int unsigned JOB_DEPTH = 2;

  // field widths
  localparam int unsigned GLOBAL_W = 32;
  localparam int unsigned LABEL_W  = 8;
  localparam int unsigned STAT_W   = 48;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADMIXED_LABEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_DIRECTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SCALE     = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  // reset values of the registers
  localparam logic [LABEL_W-1:0] ADMIXED_LABEL_RST = '0;
  localparam logic [1:0]         SHIFT_DIR_RST     = DIR_POS;
  localparam logic [SCALE_W-1:0] SCORE_SCALE_RST   = 24'd65536;

  // configuration as seen by the back end
  typedef struct packed {
    logic [LABEL_W-1:0] admixed_label;
    logic [1:0]         shift_direction;
    logic [SCALE_W-1:0] score_scale;
  } cfg_t;

endpackage

// ----- rtl/wpss_job_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_job_fifo
// short queue of finished dot products between the front and the back
// ----------------------------------------------------------------------------
`include "windowed_pca_shift_statistic_assert.svh"

module wpss_job_fifo import wpss_pkg::*; #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = JOB_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `WPSS_ASSERT_SAME(a_fifo_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth))

endmodule

// ----- rtl/wpss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_front
// accumulates genotype times loading per individual, hands off at last snp
// ----------------------------------------------------------------------------
`include "windowed_pca_shift_statistic_assert.svh"

module wpss_front import wpss_pkg::*; #(
  parameter int unsigned DotW = 30
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       full_i,
  input  logic [1:0]                 genotype_i,
  input  logic signed [15:0]         loading_i,
  input  logic signed [GLOBAL_W-1:0] global_score_i,
  input  logic [LABEL_W-1:0]         label_i,
  input  logic                       last_snp_i,
  input  logic                       last_individual_i,
  output logic                       job_push_o,
  output logic [DotW+GLOBAL_W+LABEL_W:0] job_data_o
);

  logic signed [DotW-1:0] dot_q, dot_d;
  logic signed [17:0]     term;
  logic signed [DotW:0]   sum;
  logic signed [DotW-1:0] sum_sat;
  logic                   accept;

  localparam logic signed [DotW:0] DotMax = {2'b00, {(DotW-1){1'b1}}};
  localparam logic signed [DotW:0] DotMin = {2'b11, {(DotW-1){1'b0}}};

  assign accept = push_i && !full_i;

  // term: missing genotype gives zero
  always_comb begin
    case (genotype_i)
      2'd1:    term = {{2{loading_i[15]}}, loading_i};
      2'd2:    term = {loading_i[15], loading_i, 1'b0};
      default: term = '0;
    endcase
  end

  // saturating accumulate
  always_comb begin
    sum = {dot_q[DotW-1], dot_q} + (DotW+1)'(term);
    if (sum > DotMax) begin
      sum_sat = DotMax[DotW-1:0];
    end else if (sum < DotMin) begin
      sum_sat = DotMin[DotW-1:0];
    end else begin
      sum_sat = sum[DotW-1:0];
    end
    dot_d = dot_q;
    if (accept) begin
      dot_d = last_snp_i ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
    end else begin
      dot_q <= dot_d;
    end
  end

  // finished individual goes to the queue
  assign job_push_o = accept && last_snp_i;
  assign job_data_o = {last_individual_i, label_i, global_score_i, sum_sat};

  `WPSS_ASSERT_NEXT(a_front_dot_clear, clk_i, rst_ni, accept && last_snp_i, dot_q == '0)

endmodule

// ----- rtl/wpss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpss_back
// scales the dot, forms the shift, squares it and sums it into the statistic
// ----------------------------------------------------------------------------
`include "windowed_pca_shift_statistic_assert.svh"

module wpss_back import wpss_pkg::*; #(
  parameter int unsigned DotW = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfg_t                              cfg_i,
  input  logic                              job_valid_i,
  input  logic [DotW+GLOBAL_W+LABEL_W:0]    job_data_i,
  output logic                              job_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [STAT_W-1:0]                 shift_statistic_o,
  output logic                              saturated_o
);

  localparam int unsigned ProdW = DotW + SCALE_W + 1;
  localparam logic signed [ProdW-1:0] I32Max = {{(ProdW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ProdW-1:0] I32Min = {{(ProdW-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIFF, ST_SQ, ST_ACC
  } state_e;

  state_e                      st_q;
  logic signed [DotW-1:0]      dot_q;
  logic signed [GLOBAL_W-1:0]  glob_q;
  logic [LABEL_W-1:0]          label_q;
  logic                        last_ind_q;
  logic signed [ProdW-1:0]     prod_q;
  logic [31:0]                 mag_q;
  logic                        take_q;
  logic [STAT_W-1:0]           sq_q;
  logic [STAT_W-1:0]           stat_q;
  logic                        flag_q;
  logic                        out_valid_q;
  logic [STAT_W-1:0]           out_stat_q;
  logic                        out_sat_q;

  logic signed [ProdW-1:0]     shifted;
  logic signed [GLOBAL_W-1:0]  local_score;
  logic signed [GLOBAL_W:0]    diff;
  logic                        take;
  logic [GLOBAL_W:0]           mag_full;
  logic [63:0]                 sq_full;
  logic [STAT_W:0]             acc_sum;
  logic [STAT_W-1:0]           acc_sat;
  logic                        acc_ovf;
  logic                        acc_go;
  logic                        emit;

  assign job_pop_o = (st_q == ST_IDLE) && job_valid_i;

  // local score from the scaled dot, clamped to 32 bits
  always_comb begin
    shifted = prod_q >>> 15;
    if (shifted > I32Max) begin
      local_score = I32Max[GLOBAL_W-1:0];
    end else if (shifted < I32Min) begin
      local_score = I32Min[GLOBAL_W-1:0];
    end else begin
      local_score = shifted[GLOBAL_W-1:0];
    end
    diff = {local_score[GLOBAL_W-1], local_score} - {glob_q[GLOBAL_W-1], glob_q};
    take = (label_q == cfg_i.admixed_label) &&
           (((cfg_i.shift_direction == DIR_POS) && !diff[GLOBAL_W] && (diff != '0)) ||
            ((cfg_i.shift_direction == DIR_NEG) && diff[GLOBAL_W]));
    mag_full = diff[GLOBAL_W] ? (GLOBAL_W+1)'(-diff) : diff;
  end

  // square and saturating sum
  always_comb begin
    sq_full = mag_q * mag_q;
    acc_sum = {1'b0, stat_q} + (take_q ? {1'b0, sq_q} : '0);
    acc_ovf = acc_sum[STAT_W];
    acc_sat = acc_ovf ? {STAT_W{1'b1}} : acc_sum[STAT_W-1:0];
    acc_go  = !last_ind_q || !out_valid_q || pop_i;
  end

  // statistic word loaded on the final step of the last individual
  assign emit = (st_q == ST_ACC) && acc_go && last_ind_q;

  // sequencer, statistic and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      stat_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_ind_q  <= 1'b0;
      take_q      <= 1'b0;
      dot_q       <= '0;
      glob_q      <= '0;
      label_q     <= '0;
      prod_q      <= '0;
      mag_q       <= '0;
      sq_q        <= '0;
      out_stat_q  <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            {last_ind_q, label_q, glob_q, dot_q} <= job_data_i;
            st_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q <= ProdW'(dot_q * $signed({1'b0, cfg_i.score_scale}));
          st_q   <= ST_DIFF;
        end
        ST_DIFF: begin
          mag_q  <= mag_full[31:0];
          take_q <= take;
          st_q   <= ST_SQ;
        end
        ST_SQ: begin
          sq_q <= sq_full[63:16];
          st_q <= ST_ACC;
        end
        ST_ACC: begin
          if (acc_go) begin
            if (last_ind_q) begin
              out_stat_q  <= acc_sat;
              out_sat_q   <= flag_q | acc_ovf;
              stat_q      <= '0;
              flag_q      <= 1'b0;
            end else begin
              stat_q <= acc_sat;
              flag_q <= flag_q | acc_ovf;
            end
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign empty_o           = !out_valid_q;
  assign shift_statistic_o = out_stat_q;
  assign saturated_o       = out_sat_q;

  `WPSS_ASSERT_NEXT(a_back_emit_clears, clk_i, rst_ni,
                    (st_q == ST_ACC) && acc_go && last_ind_q,
                    out_valid_q && (stat_q == '0) && !flag_q)
  `WPSS_ASSERT_NEXT(a_back_stall_holds, clk_i, rst_ni,
                    (st_q == ST_ACC) && !acc_go, (st_q == ST_ACC) && out_valid_q)
  `WPSS_ASSERT_SAME(a_back_pop_only_idle, clk_i, rst_ni, job_pop_o, st_q == ST_IDLE)

endmodule

// ----- rtl/windowed_pca_shift_statistic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_pca_shift_statistic
// per-window directional pca shift statistic over a stream of snp terms
// ----------------------------------------------------------------------------
// One SNP word is taken every cycle while full is low: the front end adds
// genotype times loading into a saturating dot accumulator. The last-SNP
// word of each individual hands the dot product to a two-entry job queue;
// the back end takes each individual through load, 30x24 scale multiply,
// clamp and subtract, 32x32 square and saturating add in turn, so the stream
// keeps its one word per cycle when windows hold five or more SNPs and
// otherwise waits on the back end. The statistic word appears on the output
// queue after the last individual and stays until popped; the back end holds
// at its final step while an unpopped statistic waits.
// ----------------------------------------------------------------------------
module windowed_pca_shift_statistic import wpss_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input queue
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 genotype_i,
  input  logic signed [15:0]         loading_i,
  input  logic signed [GLOBAL_W-1:0] global_score_i,
  input  logic [LABEL_W-1:0]         label_i,
  input  logic                       last_snp_i,
  input  logic                       last_individual_i,
  // result queue
  output logic                       empty,
  input  logic                       pop,
  output logic [STAT_W-1:0]          shift_statistic_o,
  output logic                       saturated_o,
  // register writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SCALE_W-1:0]         cfg_data_i
);

  // dot width covers WINDOW_MAX terms of magnitude up to 2^16
  localparam int unsigned DotW = 18 + $clog2(WINDOW_MAX);
  localparam int unsigned JobW = DotW + GLOBAL_W + LABEL_W + 1;

  cfg_t            cfg_q;
  logic            job_push, job_full, job_pop, job_valid;
  logic [JobW-1:0] job_wdata, job_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.admixed_label   <= ADMIXED_LABEL_RST;
      cfg_q.shift_direction <= SHIFT_DIR_RST;
      cfg_q.score_scale     <= SCORE_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ADMIXED_LABEL:   cfg_q.admixed_label   <= cfg_data_i[LABEL_W-1:0];
        CFG_SHIFT_DIRECTION: cfg_q.shift_direction <= cfg_data_i[1:0];
        CFG_SCORE_SCALE:     cfg_q.score_scale     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = job_full;

  wpss_front #(.DotW(DotW)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (job_full),
    .genotype_i        (genotype_i),
    .loading_i         (loading_i),
    .global_score_i    (global_score_i),
    .label_i           (label_i),
    .last_snp_i        (last_snp_i),
    .last_individual_i (last_individual_i),
    .job_push_o        (job_push),
    .job_data_o        (job_wdata)
  );

  wpss_job_fifo #(.Width(JobW), .Depth(JOB_DEPTH)) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .valid_o (job_valid)
  );

  wpss_back #(.DotW(DotW)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .job_valid_i       (job_valid),
    .job_data_i        (job_rdata),
    .job_pop_o         (job_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .shift_statistic_o (shift_statistic_o),
    .saturated_o       (saturated_o)
  );

endmodule

// ----- tb/tb_windowed_pca_shift_statistic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_pca_shift_statistic
// self-checking bench for the windowed pca shift statistic
// ----------------------------------------------------------------------------
// SNP words are streamed through the input queue. Each accepted word is run
// through a bit-accurate model of the dot accumulator, the Q16.16 local
// score, the directional filter and the saturating statistic. Every popped
// statistic word is compared against the oldest predicted one. Directed
// tests cover field extremes, missing genotypes, stray last-individual
// marks, zero shifts, every direction code, long windows of extreme terms,
// local score clamping and statistic saturation. Random passes then run
// under several register settings and several sender and receiver stall
// patterns.
// ----------------------------------------------------------------------------
module tb_windowed_pca_shift_statistic;
  import wpss_pkg::*;

  // direction code the block must treat like none
  localparam logic [1:0] DIR_UNUSED = 2'd3;

  localparam longint DOT_HI   = 64'sd536870911;
  localparam longint DOT_LO   = -64'sd536870912;
  localparam longint LOCAL_HI = 64'sd2147483647;
  localparam longint LOCAL_LO = -64'sd2147483648;
  localparam logic [63:0] STAT_TOP = 64'h0000_FFFF_FFFF_FFFF;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned PHASE_WORDS = 75;
  localparam int unsigned LONG_WINDOW = 40;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic              sat;
  } stat_word_t;

  // dut ports
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic [1:0]                 genotype_i = '0;
  logic signed [15:0]         loading_i = '0;
  logic signed [GLOBAL_W-1:0] global_score_i = '0;
  logic [LABEL_W-1:0]         label_i = '0;
  logic                       last_snp_i = 1'b0;
  logic                       last_individual_i = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [STAT_W-1:0]          shift_statistic_o;
  logic                       saturated_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = CFG_ADMIXED_LABEL;
  logic [SCALE_W-1:0]         cfg_data_i = '0;

  // predictor state and register copies
  logic signed [29:0]  window_dot;
  logic [STAT_W-1:0]   pass_stat;
  logic                pass_sat;
  logic [LABEL_W-1:0]  admixed_copy;
  logic [1:0]          direction_copy;
  logic [SCALE_W-1:0]  scale_copy;
  stat_word_t          stat_expected[$];

  // stall control and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned stats_checked = 0;
  int unsigned stats_saturated = 0;
  int unsigned reg_writes = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  windowed_pca_shift_statistic DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .genotype_i        (genotype_i),
    .loading_i         (loading_i),
    .global_score_i    (global_score_i),
    .label_i           (label_i),
    .last_snp_i        (last_snp_i),
    .last_individual_i (last_individual_i),
    .empty             (empty),
    .pop               (pop),
    .shift_statistic_o (shift_statistic_o),
    .saturated_o       (saturated_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mismatch reporting
  task automatic report_mismatch(input string what, input logic [STAT_W-1:0] got,
                                 input logic [STAT_W-1:0] want);
    error_count++;
    $display("[%0t] MISMATCH %s: got 0x%012h, expected 0x%012h", $time, what, got, want);
  endtask

  // advance the model by one accepted snp word
  function automatic void predict_statistic(input logic [1:0] geno,
                                            input logic signed [15:0] load,
                                            input logic signed [31:0] glob,
                                            input logic [7:0] lbl,
                                            input logic last_snp,
                                            input logic last_ind);
    longint      term;
    longint      acc;
    longint      local_score;
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] total;
    stat_word_t  word;
    term = (geno == 2'd3) ? 64'sd0 : longint'(geno) * longint'(load);
    acc = longint'(window_dot) + term;
    if (acc > DOT_HI) acc = DOT_HI;
    if (acc < DOT_LO) acc = DOT_LO;
    window_dot = acc[29:0];
    if (!last_snp) return;
    // scale into Q16.16, clamp, subtract the global score
    local_score = (longint'(window_dot) * longint'(scale_copy)) >>> 15;
    if (local_score > LOCAL_HI) local_score = LOCAL_HI;
    if (local_score < LOCAL_LO) local_score = LOCAL_LO;
    diff = local_score - longint'(glob);
    if (lbl == admixed_copy &&
        ((direction_copy == DIR_POS && diff > 0) ||
         (direction_copy == DIR_NEG && diff < 0))) begin
      mag = (diff < 0) ? -diff : diff;
      sq = (mag * mag) >> 16;
      total = {16'h0, pass_stat} + sq;
      if (total > STAT_TOP) begin
        pass_stat = '1;
        pass_sat = 1'b1;
      end else begin
        pass_stat = total[STAT_W-1:0];
      end
    end
    window_dot = '0;
    if (!last_ind) return;
    word.stat = pass_stat;
    word.sat = pass_sat;
    stat_expected.push_back(word);
    pass_stat = '0;
    pass_sat = 1'b0;
  endfunction

  // send one snp word and wait until the block takes it
  task automatic send_word(input logic [1:0] geno, input logic signed [15:0] load,
                           input logic signed [31:0] glob, input logic [7:0] lbl,
                           input logic last_snp, input logic last_ind);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push              <= 1'b1;
    genotype_i        <= geno;
    loading_i         <= load;
    global_score_i    <= glob;
    label_i           <= lbl;
    last_snp_i        <= last_snp;
    last_individual_i <= last_ind;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
    predict_statistic(geno, load, glob, lbl, last_snp, last_ind);
  endtask

  // one individual: n words of the same term, the last one closing it
  task automatic send_window(input int unsigned n, input logic [1:0] geno,
                             input logic signed [15:0] load,
                             input logic signed [31:0] glob, input logic [7:0] lbl,
                             input logic last_ind);
    repeat (n - 1) send_word(geno, load, $urandom(), 8'($urandom()), 1'b0, 1'b0);
    send_word(geno, load, glob, lbl, 1'b1, last_ind);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [SCALE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
    case (idx)
      CFG_ADMIXED_LABEL:   admixed_copy = data[LABEL_W-1:0];
      CFG_SHIFT_DIRECTION: direction_copy = data[1:0];
      CFG_SCORE_SCALE:     scale_copy = data;
      default: ;
    endcase
  endtask

  // drain, let the back end settle, then write all three registers
  task automatic set_config(input logic [7:0] lbl, input logic [1:0] dir,
                            input logic [SCALE_W-1:0] scale);
    push <= 1'b0;
    while (stat_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_register(CFG_ADMIXED_LABEL, {16'h0, lbl});
    write_register(CFG_SHIFT_DIRECTION, {22'h0, dir});
    write_register(CFG_SCORE_SCALE, scale);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      1: begin send_idle_pct = 55; pop_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct = 55; end
      3: begin send_idle_pct = 11; pop_stall_pct = 11; end
      default: begin send_idle_pct = 0; pop_stall_pct = 0; end
    endcase
  endtask

  // one pass over random individuals with mostly matching labels
  task automatic send_random_pass();
    int unsigned       n_ind;
    int unsigned       n_snp;
    int unsigned       pick;
    logic [1:0]        geno;
    logic signed [15:0] load;
    logic signed [31:0] glob;
    logic [7:0]        lbl;
    n_ind = $urandom_range(1, 6);
    for (int i = 0; i < n_ind; i++) begin
      n_snp = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      pick = $urandom_range(0, 9);
      if (pick < 4)      glob = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      else if (pick < 6) glob = $urandom();
      else if (pick < 7) glob = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else               glob = $urandom_range(0, 2000) - 1000;
      lbl = ($urandom_range(0, 9) < 7) ? admixed_copy : 8'($urandom());
      for (int s = 0; s < n_snp; s++) begin
        geno = ($urandom_range(0, 9) == 9) ? 2'd3 : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 15)
          load = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
          load = 16'($urandom());
        if (s == n_snp - 1)
          send_word(geno, load, glob, lbl, 1'b1, i == n_ind - 1);
        else
          send_word(geno, load, $urandom(), 8'($urandom()), 1'b0,
                    $urandom_range(0, 19) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // label 0, positive shifts, unit scale straight out of reset
    send_word(2'd1, 16'sd1000, 32'sd0, 8'd0, 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    set_idle(1);
    // non-matching label at the negative global extreme
    send_word(2'd2, -16'sd32768, $urandom(), 8'($urandom()), 1'b0, 1'b0);
    send_word(2'd2, 16'sd32767, $urandom(), 8'($urandom()), 1'b0, 1'b0);
    send_word(2'd0, 16'sd12345, $urandom(), 8'($urandom()), 1'b0, 1'b0);
    send_word(2'd3, 16'sd32767, 32'sh8000_0000, 8'd255, 1'b1, 1'b0);
    // negative shift while positive ones are counted
    send_word(2'd1, 16'sd32767, 32'sh7FFF_FFFF, 8'd0, 1'b1, 1'b0);
    // most negative term against the most negative global score
    send_word(2'd2, -16'sd32768, 32'sh8000_0000, 8'd0, 1'b1, 1'b1);
    set_idle(0);
  endtask

  task automatic test_special_cases();
    set_config(8'd9, DIR_POS, 24'd65536);
    // zero shift, then a missing genotype and a stray last-individual mark
    send_word(2'd1, 16'sd16384, 32'sd32768, 8'd9, 1'b1, 1'b0);
    send_word(2'd3, 16'sd32767, $urandom(), 8'($urandom()), 1'b0, 1'b0);
    send_word(2'd1, 16'sd100, $urandom(), 8'd9, 1'b0, 1'b1);
    send_word(2'd1, 16'sd900, 32'sd0, 8'd9, 1'b1, 1'b1);
    // negative, none and unused direction codes on the same negative shift
    set_config(8'd9, DIR_NEG, 24'd65536);
    send_word(2'd2, -16'sd5000, 32'sd0, 8'd9, 1'b1, 1'b1);
    set_config(8'd9, DIR_NONE, 24'd65536);
    send_word(2'd2, -16'sd5000, 32'sd0, 8'd9, 1'b1, 1'b1);
    set_config(8'd9, DIR_UNUSED, 24'd65536);
    send_word(2'd2, -16'sd5000, 32'sd0, 8'd9, 1'b1, 1'b1);
  endtask

  task automatic test_long_windows();
    // dot accumulator driven in both directions by long windows of extreme terms
    set_config(8'd0, DIR_POS, 24'd65536);
    send_window(LONG_WINDOW, 2'd2, 16'sd32767, 32'sd0, 8'd0, 1'b1);
    set_config(8'd0, DIR_NEG, 24'd65536);
    send_window(LONG_WINDOW, 2'd2, -16'sd32768, 32'sd0, 8'd0, 1'b1);
    // clamped local score, statistic saturates, flag clears on the next pass
    set_config(8'd0, DIR_POS, 24'hFF_FFFF);
    send_window(70, 2'd2, 16'sd32767, 32'sh8000_0000, 8'd0, 1'b0);
    send_window(70, 2'd2, 16'sd32767, 32'sh8000_0000, 8'd0, 1'b0);
    send_window(70, 2'd2, 16'sd32767, 32'sh8000_0000, 8'd0, 1'b1);
    send_word(2'd1, 16'sd1, 32'sd0, 8'd0, 1'b1, 1'b1);
  endtask

  task automatic test_random_passes();
    int unsigned start;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(8'($urandom()), DIR_POS, 24'd65536);
        1: set_config(8'd0, DIR_NEG, 24'hFF_FFFF);
        2: set_config(8'd255, DIR_POS, 24'd0);
        3: set_config(8'($urandom()), DIR_NEG, 24'($urandom_range(0, 24'hFF_FFFF)));
        4: set_config(8'($urandom()), DIR_NONE, 24'($urandom_range(0, 24'hFF_FFFF)));
        5: set_config(8'($urandom()), DIR_UNUSED, 24'($urandom_range(0, 24'hFF_FFFF)));
        6: set_config(8'($urandom()), DIR_POS, 24'($urandom_range(1, 65536)));
        7: set_config(8'($urandom()), DIR_NEG, 24'($urandom_range(0, 24'hFF_FFFF)));
        default: set_config(8'($urandom()), DIR_POS, 24'hFF_FFFF);
      endcase
      set_idle(ph % 4);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) send_random_pass();
    end
    set_idle(0);
  endtask

  // ------------------------------------------------------------ sequencing

  initial begin
    window_dot     = '0;
    pass_stat      = '0;
    pass_sat       = 1'b0;
    admixed_copy   = ADMIXED_LABEL_RST;
    direction_copy = SHIFT_DIR_RST;
    scale_copy     = SCORE_SCALE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_special_cases();
    test_long_windows();
    test_random_passes();
    push <= 1'b0;
    while (stat_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d snp words and %0d register writes", words_sent, reg_writes);
    $display("%0d statistic words checked, %0d of them saturated, %0d mismatches",
             stats_checked, stats_saturated, error_count);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // result side: random pop stalls
  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // compare each popped statistic word against the oldest prediction
  always @(posedge clk_i) begin
    stat_word_t want;
    if (rst_ni && pop && !empty) begin
      if (stat_expected.size() == 0) begin
        report_mismatch("statistic word with none expected", shift_statistic_o, '0);
      end else begin
        want = stat_expected.pop_front();
        stats_checked++;
        if (want.sat) stats_saturated++;
        if (shift_statistic_o !== want.stat)
          report_mismatch("shift_statistic", shift_statistic_o, want.stat);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", {47'h0, saturated_o}, {47'h0, want.sat});
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wpss_pkg.sv
rtl/wpss_job_fifo.sv
rtl/wpss_front.sv
rtl/wpss_back.sv
rtl/windowed_pca_shift_statistic.sv
tb/tb_windowed_pca_shift_statistic.sv
